[design/plist_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list store package
// Shared types and constants for the list store controller and datapath.
// ----------------------------------------------------------------------------
package plist_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   // Action codes carried in the request transaction.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] position;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] data;
      status_type status;
      logic [4:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_CHECK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic {
      WR_SHIFT,
      WR_PLACE
   } wr_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_POS,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      idx_op_type idx_op;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       got_load;
      logic       res_load;
      status_type res_status;
      logic       res_use_got;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] action;
      logic       pos_gt_count;
      logic       pos_ge_count;
      logic       count_zero;
      logic       full;
      logic       idx_eq_pos;
      logic       idx_next_lt_count;
      logic       out_free;
   } stat_type;

endpackage

[design/plist_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list store datapath
// Entry memory, count, walking index, request latch and result register.
// ----------------------------------------------------------------------------
module plist_datapath #(
   parameter int CAPACITY = plist_pkg::DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  plist_pkg::req_type req_item,
   input  plist_pkg::cmd_type cmd,
   output plist_pkg::stat_type stat,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output plist_pkg::rsp_type rsp_item
);
   import plist_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int W  = (CW > 5) ? CW : 5;

   logic [7:0]    mem [CAPACITY];
   logic [7:0]    rdata_ff;
   logic [7:0]    got_ff;
   logic [1:0]    action_ff;
   logic [4:0]    pos_ff;
   logic [7:0]    value_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_item_ff;

   logic [W-1:0]  pos_ext, cnt_ext, idx_ext;
   logic [CW-1:0] idx_prev, idx_next;
   logic [CW:0]   idx_next_wide;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    wr_data;

   always_comb begin
      pos_ext       = W'(pos_ff);
      cnt_ext       = W'(count_ff);
      idx_ext       = W'(idx_ff);
      idx_prev      = idx_ff - CW'(1);
      idx_next      = idx_ff + CW'(1);
      idx_next_wide = {1'b0, idx_ff} + (CW+1)'(1);
   end

   always_comb begin
      stat.action            = action_ff;
      stat.pos_gt_count      = pos_ext > cnt_ext;
      stat.pos_ge_count      = pos_ext >= cnt_ext;
      stat.count_zero        = count_ff == '0;
      stat.full              = count_ff == CW'(CAPACITY);
      stat.idx_eq_pos        = idx_ext == pos_ext;
      stat.idx_next_lt_count = idx_next_wide < {1'b0, count_ff};
      stat.out_free          = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_POS:  rd_addr = pos_ext[AW-1:0];
         RD_PREV: rd_addr = idx_prev[AW-1:0];
         RD_NEXT: rd_addr = idx_next[AW-1:0];
         default: rd_addr = pos_ext[AW-1:0];
      endcase
      if (cmd.wr_sel == WR_PLACE) begin
         wr_addr = pos_ext[AW-1:0];
         wr_data = value_ff;
      end else begin
         wr_addr = idx_ff[AW-1:0];
         wr_data = rdata_ff;
      end
   end

   always_comb begin
      unique case (cmd.idx_op)
         IDX_HOLD:  idx_in = idx_ff;
         IDX_COUNT: idx_in = count_ff;
         IDX_POS:   idx_in = CW'(pos_ext);
         IDX_DEC:   idx_in = idx_prev;
         IDX_INC:   idx_in = idx_next;
         default:   idx_in = idx_ff;
      endcase
      priority if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
      priority if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff <= req_item.action;
         pos_ff    <= req_item.position;
         value_ff  <= req_item.value;
      end
      if (cmd.got_load) begin
         got_ff <= rdata_ff;
      end
      idx_ff <= idx_in;
      if (cmd.res_load) begin
         rsp_item_ff.data        <= cmd.res_use_got ? got_ff : 8'd0;
         rsp_item_ff.status      <= cmd.res_status;
         rsp_item_ff.entry_count <= cnt_ext[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[design/plist_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list store controller
// Sequences decode, entry shifting and result hand-off for one transaction.
// ----------------------------------------------------------------------------
module plist_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  plist_pkg::stat_type stat,
   output plist_pkg::cmd_type  cmd
);
   import plist_pkg::*;

   ctrl_state_type state_ff, state_in;
   status_type     code_ff, code_in;
   logic           is_insert;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   always_comb begin
      is_insert       = stat.action == ACT_INSERT;
      state_in        = state_ff;
      code_in         = code_ff;
      req_stall       = 1'b1;
      cmd.latch       = 1'b0;
      cmd.rd_en       = 1'b0;
      cmd.rd_sel      = RD_POS;
      cmd.wr_en       = 1'b0;
      cmd.wr_sel      = WR_SHIFT;
      cmd.idx_op      = IDX_HOLD;
      cmd.cnt_inc     = 1'b0;
      cmd.cnt_dec     = 1'b0;
      cmd.got_load    = 1'b0;
      cmd.res_load    = 1'b0;
      cmd.res_status  = code_ff;
      cmd.res_use_got = (code_ff == ST_OK) && !is_insert;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (is_insert) begin
               priority if (stat.pos_gt_count) begin
                  code_in  = ST_RANGE;
                  state_in = S_DONE;
               end else if (stat.full) begin
                  code_in  = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  code_in    = ST_OK;
                  cmd.idx_op = IDX_COUNT;
                  state_in   = S_CHECK;
               end
            end else if (stat.action == ACT_DELETE || stat.action == ACT_READ) begin
               priority if (stat.count_zero) begin
                  code_in  = ST_EMPTY;
                  state_in = S_DONE;
               end else if (stat.pos_ge_count) begin
                  code_in  = ST_RANGE;
                  state_in = S_DONE;
               end else begin
                  code_in    = ST_OK;
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_POS;
                  state_in   = S_FETCH;
               end
            end else begin
               code_in  = ST_RANGE;
               state_in = S_DONE;
            end
         end
         S_FETCH: begin
            cmd.got_load = 1'b1;
            if (stat.action == ACT_DELETE) begin
               cmd.idx_op = IDX_POS;
               state_in   = S_CHECK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            if (is_insert) begin
               state_in = stat.idx_eq_pos ? S_PLACE : S_SHIFT_RD;
            end else if (stat.idx_next_lt_count) begin
               state_in = S_SHIFT_RD;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_SHIFT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = is_insert ? RD_PREV : RD_NEXT;
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            cmd.idx_op = is_insert ? IDX_DEC : IDX_INC;
            state_in   = S_CHECK;
         end
         S_PLACE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_PLACE;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[design/positional_list_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list store
// Ordered byte sequence with insert, delete and read at a position.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake             Payload
//   req      in   req_valid/req_stall   req_item: action, position, value
//   rsp      out  rsp_valid/rsp_stall   rsp_item: data, status, entry_count
//
// One transaction is handled at a time. Entries live in a single-port-write,
// registered-read memory, and insert or delete moves the entries behind the
// position one at a time, each moved entry taking a read, a write and a check
// step. Errors go from decode straight to the result; a read adds a fetch,
// insert adds the shifts and a place step, delete a fetch and the shifts.
// The controller passes through idle before it accepts the next request.
// Reset clears the count and the result valid; memory contents are not
// cleared and are only read below the count. The result register frees the
// controller once loaded, so a new request is accepted while the previous
// result still waits on rsp_stall; that request finishes only once the result
// register is free again.
// ----------------------------------------------------------------------------
module positional_list_store #(
   parameter int CAPACITY = plist_pkg::DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  plist_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output plist_pkg::rsp_type rsp_item
);
   import plist_pkg::*;

   // Commands and status between the controller and the datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller decides the sequence of memory moves from the status
   // compares that the datapath makes against the count and walking index.
   plist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the entries, count, index and the result register.
   plist_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // A memory read and write are never issued in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("memory read and write issued together");

   // Any error status carries zero data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ST_OK) |-> (rsp_item.data == 8'd0))
      else $error("error result with nonzero data");

   // A full status is only reported with the sequence at capacity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_FULL) |->
         (rsp_item.entry_count == 5'(CAPACITY)))
      else $error("full status with sequence below capacity");

   // An accepted request never produces its result in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !cmd.res_load)
      else $error("result loaded too early after acceptance");

endmodule

[dv/tb_positional_list_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list store testbench
// Sends insert, delete, read and unused-action transactions to the list store
// with random idle gaps and result stalls. A queue-based model of the byte
// sequence predicts every result, and the monitor checks each result in order.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
   import plist_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;

   // Action code 3 has no meaning and must come back as a range error.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1750;

   // The slowest transactions are an insert at position 0 into CAPACITY - 1
   // entries and a delete at position 0 when full; the tail wait covers them.
   localparam int TAIL_CYCLES = 64;

   // Cycles with nothing moving on either channel before the run is abandoned.
   // The worst honest wait is a long request gap plus the longest insert
   // plus a long result stall.
   localparam int IDLE_LIMIT = 2000;

   // DUT interface.
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   // Stimulus waiting for the driver, and results waiting for the DUT.
   req_type pending_requests[$];
   rsp_type expected_results[$];

   // Model of the stored sequence, front of the queue at position 0.
   logic [7:0] stored_bytes[$];

   // Fill level seen by the stimulus generator while it builds the queue.
   int gen_fill = 0;

   int total_requests = 0;
   int accepted_requests = 0;
   int error_count = 0;
   int idle_cycles = 0;

   // Flow control state for the driver and the result stall generator.
   logic req_taken = 1'b0;
   int   req_gap_left = 0;
   int   req_quiet_left = 0;
   int   rsp_stall_left = 0;
   int   rsp_quiet_left = 0;

   positional_list_store #(
      .CAPACITY (CAPACITY)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one action to the sequence model and returns the result the
   // DUT must produce for it. Errors never change the sequence, and the
   // empty check on delete and read comes before the position check.
   function automatic rsp_type apply_list_action(req_type item);
      rsp_type     res;
      int unsigned fill;
      int unsigned pos;
      fill = stored_bytes.size();
      pos = item.position;
      res.data = '0;
      res.status = ST_OK;
      case (item.action)
         ACT_INSERT: begin
            if (pos > fill) begin
               res.status = ST_RANGE;
            end else if (fill >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               stored_bytes.insert(pos, item.value);
            end
         end
         ACT_DELETE, ACT_READ: begin
            if (fill == 0) begin
               res.status = ST_EMPTY;
            end else if (pos >= fill) begin
               res.status = ST_RANGE;
            end else begin
               res.data = stored_bytes[pos];
               if (item.action == ACT_DELETE) begin
                  stored_bytes.delete(pos);
               end
            end
         end
         default: begin
            res.status = ST_RANGE;
         end
      endcase
      res.entry_count = 5'(stored_bytes.size());
      return res;
   endfunction

   // Queues one request and tracks the fill level it leads to, so that the
   // generator can aim positions at the live part of the sequence.
   function automatic void queue_request(logic [1:0] act, logic [4:0] pos, logic [7:0] val);
      req_type item;
      item.action = act;
      item.position = pos;
      item.value = val;
      pending_requests.push_back(item);
      total_requests++;
      if (act == ACT_INSERT && pos <= gen_fill && gen_fill < CAPACITY) begin
         gen_fill++;
      end else if (act == ACT_DELETE && gen_fill > 0 && pos < gen_fill) begin
         gen_fill--;
      end
   endfunction

   // Idle length for either side: mostly none or short, a few long, and now
   // and then a quiet stretch in which no idling happens at all.
   function automatic int pick_idle_gap(inout int quiet_left);
      int roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         quiet_left = $urandom_range(30, 150);
         return 0;
      end else if (roll < 62) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // Driver. A transaction stays on the bus until the monitor has seen it
   // accepted; only then does the driver idle or present the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left = req_gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_item <= pending_requests.pop_front();
            req_valid <= 1'b1;
            req_gap_left = pick_idle_gap(req_quiet_left);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure, drawn one stretch at a time.
   always @(negedge clock) begin
      if (rsp_stall_left == 0) begin
         rsp_stall_left = pick_idle_gap(rsp_quiet_left);
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor. Results are checked before the request of the same edge is
   // predicted, since a result can only belong to an earlier transaction.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result %p", rsp_item));
            end else begin
               if (rsp_item.data !== expected_results[0].data) begin
                  report_mismatch($sformatf("data %0h, expected %0h",
                                            rsp_item.data, expected_results[0].data));
               end
               if (rsp_item.status !== expected_results[0].status) begin
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_item.status,
                                            expected_results[0].status.name()));
               end
               if (rsp_item.entry_count !== expected_results[0].entry_count) begin
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_item.entry_count,
                                            expected_results[0].entry_count));
               end
               void'(expected_results.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            req_taken = 1'b1;
            accepted_requests++;
            expected_results.push_back(apply_list_action(req_item));
         end
      end
   end

   // Watchdog: the run is stuck if nothing moves on either channel.
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
      end
      $display("positional_list_store regression: fail");
      $finish;
   end

   initial begin
      int n;
      int k;
      int roll;
      int target;
      int span;
      logic [1:0] act;
      logic [4:0] pos;

      // Directed part: errors on an empty store, then a full sweep up to
      // capacity with inserts at the front, the end and the middle.
      queue_request(ACT_READ, 5'd0, 8'h00);
      queue_request(ACT_DELETE, 5'd0, 8'hFF);
      queue_request(ACT_UNUSED, 5'd0, 8'h5A);
      queue_request(ACT_INSERT, 5'd31, 8'hFF);
      for (k = 0; k < CAPACITY; k++) begin
         case (k % 3)
            0: pos = 5'(gen_fill);
            1: pos = 5'd0;
            default: pos = 5'(gen_fill / 2);
         endcase
         queue_request(ACT_INSERT, pos, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom));
      end
      // Insert at the end while full reports full; one further out is a
      // range error, since the position check comes first.
      queue_request(ACT_INSERT, 5'(CAPACITY), 8'h11);
      queue_request(ACT_INSERT, 5'(CAPACITY + 1), 8'h22);
      queue_request(ACT_READ, 5'(CAPACITY - 1), 8'h00);
      queue_request(ACT_READ, 5'(CAPACITY), 8'h00);
      queue_request(ACT_DELETE, 5'(CAPACITY - 1), 8'h00);
      queue_request(ACT_DELETE, 5'd0, 8'h00);

      // Random part. The fill level is steered toward a target that changes
      // every few dozen transactions so that empty, full and everything in
      // between see long stretches of legal traffic. A share of the traffic
      // is noise with any action and any position.
      target = CAPACITY;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 5))
               0: target = 0;
               1: target = 1;
               2: target = CAPACITY;
               3: target = CAPACITY - 1;
               default: target = $urandom_range(0, CAPACITY);
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            queue_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                          8'($urandom_range(0, 255)));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
               act = ACT_READ;
            end else if (gen_fill < target || (gen_fill == target && roll < 60)) begin
               act = ACT_INSERT;
            end else begin
               act = ACT_DELETE;
            end
            if (act == ACT_INSERT) begin
               span = gen_fill;
            end else begin
               span = (gen_fill > 0) ? gen_fill - 1 : 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
               pos = 5'd0;
            end else if (roll < 50) begin
               pos = 5'(span);
            end else begin
               pos = 5'($urandom_range(0, span));
            end
            queue_request(act, pos, 8'($urandom_range(0, 255)));
         end
      end

      // Synchronous reset, released on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: every request accepted, every result seen, then a tail long
      // enough for a stray result from the slowest transaction to show up.
      wait (accepted_requests == total_requests);
      wait (expected_results.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end

      if (error_count == 0) begin
         $display("positional_list_store regression: pass");
      end else begin
         $display("positional_list_store regression: fail");
      end
      $finish;
   end

endmodule
